/* hdl/edf_pkg.sv */
// ----------------------------------------------------------------------------
// edf_pkg
// Shared constants and result type for the escaped frame deframer.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hE0;
  localparam logic [7:0] ESC_BYTE  = 8'hD0;
  localparam logic [7:0] WAIT_LEN  = 8'hFF;
  localparam logic [7:0] CMD_INDEX = 8'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       frame_end;
    logic       checksum_ok;
    logic [7:0] command_code;
  } result_t;

endpackage

/* hdl/escaped_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// escaped_frame_deframer_unit
// Byte-stuffed serial frame deframer with 8-bit sum checksum.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+-------------------------------------------------------
//  in      | sink      | in_valid, in_stall, in_rx_byte
//  out     | source    | out_valid, out_stall, out_data_byte, out_byte_index,
//          |           | out_frame_end, out_checksum_ok, out_command_code
//
//  One byte per cycle sustained while the output is not stalled; each byte
//  passes the input register, then the state update into the result register.
//  Synchronous active-low reset clears the frame state and both valid flags.
//  An output stall holds the result register and backs up to in_stall only
//  once the input register is also occupied.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_byte_index,
  output logic       out_frame_end,
  output logic       out_checksum_ok,
  output logic [7:0] out_command_code
);
  import edf_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_ready;
  logic       fire;
  logic       has_result;
  result_t    core_result;
  result_t    out_result;

  assign fire = s1_valid && out_ready;

  edf_input_reg u_input_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .advance_i (out_ready),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte)
  );

  edf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire_i      (fire),
    .byte_i      (s1_byte),
    .has_result_o(has_result),
    .result_o    (core_result)
  );

  edf_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (fire && has_result),
    .result_i (core_result),
    .ready_o  (out_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_o (out_result)
  );

  assign out_data_byte    = out_result.data_byte;
  assign out_byte_index   = out_result.byte_index;
  assign out_frame_end    = out_result.frame_end;
  assign out_checksum_ok  = out_result.checksum_ok;
  assign out_command_code = out_result.command_code;

`ifndef ASSERT_OFF
  // input side only backs up when a result is held by a stalled consumer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_valid))
    else $error("in_stall without a stalled result");

  // a new result only appears after the input register held a byte
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a buffered byte");

  // results always carry a frame position of at least one
  a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_index != 8'd0))
    else $error("result with zero byte index");
`endif

endmodule

/* hdl/edf_input_reg.sv */
// ----------------------------------------------------------------------------
// edf_input_reg
// Input register stage: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module edf_input_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_stall = valid_r && !advance_i;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign valid_o = valid_r;
  assign byte_o  = byte_r;

endmodule

/* hdl/edf_core.sv */
// ----------------------------------------------------------------------------
// edf_core
// Deframer state machine: sync/length/escape handling, running sum, command
// capture and per-byte result generation.
// ----------------------------------------------------------------------------
module edf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  output logic              has_result_o,
  output edf_pkg::result_t  result_o
);
  import edf_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_FRAME = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] val;

  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    esc_nxt      = esc_r;
    cmd_nxt      = cmd_r;
    val          = byte_i;
    has_result_o = 1'b0;
    result_o     = '0;

    if (byte_i == SYNC_BYTE) begin
      // sync restarts from anywhere and drops a pending escape
      phase_nxt = PH_LEN;
      esc_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt = byte_i;
          cnt_nxt = '0;
          sum_nxt = byte_i;
          cmd_nxt = '0;
          if (byte_i == 8'd0) begin
            phase_nxt = PH_IDLE;
          end else if (byte_i == WAIT_LEN) begin
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_FRAME;
          end
        end
        PH_FRAME: begin
          if (byte_i == ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else begin
            val     = esc_r ? byte_i + 8'd1 : byte_i;
            esc_nxt = 1'b0;
            cnt_nxt = cnt_r + 8'd1;
            if (cnt_nxt == CMD_INDEX) begin
              cmd_nxt = val;
            end
            has_result_o        = 1'b1;
            result_o.data_byte  = val;
            result_o.byte_index = cnt_nxt;
            if (cnt_nxt == len_r) begin
              result_o.frame_end    = 1'b1;
              result_o.checksum_ok  = (sum_r == val);
              result_o.command_code = cmd_nxt;
              phase_nxt             = PH_IDLE;
            end else begin
              sum_nxt = sum_r + val;
            end
          end
        end
        default: ; // idle and unused code: byte ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      esc_r   <= 1'b0;
      cmd_r   <= '0;
    end else if (fire_i) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      esc_r   <= esc_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

/* hdl/edf_out_reg.sv */
// ----------------------------------------------------------------------------
// edf_out_reg
// Result register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module edf_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_i,
  input  edf_pkg::result_t result_i,
  output logic             ready_o,
  output logic             out_valid,
  input  logic             out_stall,
  output edf_pkg::result_t result_o
);
  import edf_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign ready_o = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (ready_o) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign out_valid = valid_r;
  assign result_o  = result_r;

endmodule

/* bench/escaped_frame_deframer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_unit_test
// Self-checking bench for the escaped frame deframer. A directed table walks
// sync, length, escape and checksum corner cases. Random well-formed frames
// follow, mixed with noise and cut-short frames. Every output transfer is
// compared with a local model of the deframer or, for some directed rows, with a
// typed-in result. Phases vary the sender gaps and the receiver stalls, and one
// phase holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_unit_test;
  import edf_pkg::*;

  localparam int DIRECTED_ROWS = 26;
  localparam int RANDOM_ROWS   = 281;    // per random phase
  localparam int PHASES        = 5;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 8;

  localparam int IDLE_PCT  [PHASES] = '{0, 0, 50, 0, 12};
  localparam int STALL_PCT [PHASES] = '{0, 0, 0, 50, 12};

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_kind_t;
  typedef enum logic [1:0] {PH_IDLE, PH_LENGTH, PH_BODY, PH_SPARE} frame_phase_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] rx;
    result_t    res;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  // kind, raw byte, result where it is typed in
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SILENT,  8'h55, NO_RES},                               // idle, ignored
    '{ROW_SILENT,  8'hE0, NO_RES},
    '{ROW_SILENT,  8'h00, NO_RES},                               // length zero
    '{ROW_SILENT,  8'h42, NO_RES},                               // back in idle
    '{ROW_SILENT,  8'hE0, NO_RES},
    '{ROW_SILENT,  8'hFF, NO_RES},                               // keep awaiting length
    '{ROW_SILENT,  8'h03, NO_RES},
    '{ROW_PREDICT, 8'h10, NO_RES},
    '{ROW_SILENT,  8'hD0, NO_RES},
    '{ROW_PREDICT, 8'hFF, NO_RES},                               // escaped, wraps to 0
    '{ROW_TYPED,   8'h13, '{8'h13, 8'h03, 1'b1, 1'b1, 8'h13}},   // checksum byte, also captured as command
    '{ROW_SILENT,  8'hE0, NO_RES},
    '{ROW_SILENT,  8'h02, NO_RES},
    '{ROW_SILENT,  8'hD0, NO_RES},
    '{ROW_SILENT,  8'hE0, NO_RES},                               // sync drops the escape
    '{ROW_SILENT,  8'h01, NO_RES},
    '{ROW_TYPED,   8'h01, '{8'h01, 8'h01, 1'b1, 1'b1, 8'h00}},   // short frame
    '{ROW_SILENT,  8'hE0, NO_RES},
    '{ROW_SILENT,  8'h05, NO_RES},
    '{ROW_SILENT,  8'hD0, NO_RES},
    '{ROW_SILENT,  8'hD0, NO_RES},                               // escape stays pending
    '{ROW_PREDICT, 8'h7F, NO_RES},
    '{ROW_PREDICT, 8'hFF, NO_RES},
    '{ROW_PREDICT, 8'h2A, NO_RES},
    '{ROW_PREDICT, 8'hAE, NO_RES},
    '{ROW_TYPED,   8'h00, '{8'h00, 8'h05, 1'b1, 1'b0, 8'h2A}}    // bad checksum
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_data_byte;
  logic [7:0] out_byte_index;
  logic       out_frame_end;
  logic       out_checksum_ok;
  logic [7:0] out_command_code;

  // model state, reset values
  frame_phase_t fr_phase   = PH_IDLE;
  logic [7:0]   fr_length  = 8'h00;
  logic [7:0]   fr_count   = 8'h00;
  logic [7:0]   fr_sum     = 8'h00;
  logic [7:0]   fr_command = 8'h00;
  logic         fr_escape  = 1'b0;

  result_t   deframed_q [$];
  stim_row_t stim [$];
  int        seg_end [PHASES];
  int        fails     = 0;
  int        taken     = 0;
  int        cycles    = 0;
  int        idle_pct  = 0;
  int        stall_pct = 0;
  int        hold_seq  = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  escaped_frame_deframer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_end    (out_frame_end),
    .out_checksum_ok  (out_checksum_ok),
    .out_command_code (out_command_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit deframe_step(input logic [7:0] rx, output result_t r);
    logic [7:0] b;
    b = rx;
    r = '0;
    if (b == SYNC_BYTE) begin
      fr_phase  = PH_LENGTH;
      fr_escape = 1'b0;
      return 1'b0;
    end
    if (fr_phase == PH_LENGTH) begin
      fr_length  = b;
      fr_count   = 8'h00;
      fr_sum     = b;
      fr_command = 8'h00;
      if (b == 8'h00) fr_phase = PH_IDLE;
      else if (b == WAIT_LEN) fr_phase = PH_LENGTH;
      else fr_phase = PH_BODY;
      return 1'b0;
    end
    if (fr_phase != PH_BODY) return 1'b0;
    if (b == ESC_BYTE) begin
      fr_escape = 1'b1;
      return 1'b0;
    end
    if (fr_escape) begin
      b = b + 8'd1;
      fr_escape = 1'b0;
    end
    fr_count = fr_count + 8'd1;
    if (fr_count == CMD_INDEX) fr_command = b;
    r.data_byte  = b;
    r.byte_index = fr_count;
    if (fr_count == fr_length) begin
      r.frame_end    = 1'b1;
      r.checksum_ok  = (fr_sum == b);
      r.command_code = fr_command;
      fr_phase       = PH_IDLE;
    end else begin
      fr_sum = fr_sum + b;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, seen);
      fails++;
    end
  endfunction

  function automatic void add_row(logic [7:0] b);
    stim_row_t r;
    r.kind = ROW_PREDICT;
    r.rx   = b;
    r.res  = '0;
    stim.push_back(r);
  endfunction

  // result check first: an output transfer always belongs to an older input
  always @(posedge clk) begin : monitor
    result_t want;
    result_t pred;
    bit      made;
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: result expected none, actual data %h index %h", $time,
                 out_data_byte, out_byte_index);
        fails++;
      end else begin
        want = deframed_q.pop_front();
        check_field("data_byte", want.data_byte, out_data_byte);
        check_field("byte_index", want.byte_index, out_byte_index);
        check_field("frame_end", {7'h00, want.frame_end}, {7'h00, out_frame_end});
        check_field("checksum_ok", {7'h00, want.checksum_ok}, {7'h00, out_checksum_ok});
        check_field("command_code", want.command_code, out_command_code);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      made = deframe_step(in_rx_byte, pred);
      case (stim[taken].kind)
        ROW_PREDICT: if (made) deframed_q.push_back(pred);
        ROW_TYPED:   deframed_q.push_back(stim[taken].res);
        default: ;
      endcase
      taken++;
    end
  end

  // receiver: a long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_seq;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int         len, cut, k, n, s;
    logic [7:0] v, sum;

    for (k = 0; k < DIRECTED_ROWS; k++) stim.push_back(DIRECTED[k]);
    seg_end[0] = stim.size();
    for (s = 1; s < PHASES; s++) begin
      while (stim.size() < DIRECTED_ROWS + s * RANDOM_ROWS) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 3)) add_row(8'($urandom));
        end
        n = $urandom_range(99);
        if (n < 3) len = $urandom_range(200, 254);
        else if (n < 10) len = $urandom_range(13, 40);
        else if (n < 13) len = 0;
        else len = $urandom_range(1, 12);
        if (len == SYNC_BYTE) len--;
        add_row(SYNC_BYTE);
        if ($urandom_range(19) == 0) add_row(WAIT_LEN);
        add_row(len[7:0]);
        // now and then a frame is cut short; the next sync restarts
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, len) : len + 1;
        sum = len[7:0];
        for (k = 1; k <= len && k < cut; k++) begin
          if (k < len) v = 8'($urandom);
          else if ($urandom_range(7) == 0) v = 8'($urandom);
          else v = sum;
          // stuff sync and escape values, and some others at random
          if (v == SYNC_BYTE || v == ESC_BYTE ||
              ($urandom_range(9) == 0 && v - 8'd1 != SYNC_BYTE &&
               v - 8'd1 != ESC_BYTE)) begin
            add_row(ESC_BYTE);
            if ($urandom_range(3) == 0) add_row(ESC_BYTE);
            add_row(v - 8'd1);
          end else begin
            add_row(v);
          end
          sum = sum + v;
        end
        if (cut <= len && $urandom_range(1) == 0) add_row(ESC_BYTE);
      end
      seg_end[s] = stim.size();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    n = 0;
    for (s = 0; s < PHASES; s++) begin
      idle_pct  <= IDLE_PCT[s];
      stall_pct <= STALL_PCT[s];
      if (s == 1) hold_seq <= hold_seq + 1;
      for (; n < seg_end[s]; n++) begin
        while ($urandom_range(99) < idle_pct) begin
          in_valid   <= 1'b0;
          in_rx_byte <= 8'($urandom);
          @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_rx_byte <= stim[n].rx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
      end
      // sender pauses until every pending result has been transferred
      in_valid <= 1'b0;
      @(posedge clk);
      while (deframed_q.size() != 0) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
